// ----- sv/vbc_pkg.sv -----
// Package for the Vigenere byte cipher: widths, character codes, register
// indexes and the item type handed from the front end to the back end.
// No dependencies.
package vbc_pkg;

  localparam int BYTE_W          = 8;
  localparam int SHIFT_W         = 5;
  localparam int KEY_LETTERS     = 12;
  localparam int KEY_SHIFTS_W    = KEY_LETTERS * SHIFT_W;
  localparam int KEY_LENGTH_W    = 4;
  localparam int POS_W           = 4;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = KEY_SHIFTS_W;
  localparam int MAX_KEY_LETTERS = 12;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [SHIFT_W-1:0] ALPHABET_LEN = 5'd26;

  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_SHIFTS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT_MODE = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               letter;
    logic [SHIFT_W-1:0] shift;
  } queue_entry_t;

endpackage

// ----- sv/vbc_in_if.sv -----
// Input channel of the Vigenere byte cipher: valid/ready, one message byte and message_start.
// Depends on vbc_pkg.
interface vbc_in_if;
  import vbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              message_start;

  modport source (output valid, output byte_in, output message_start, input ready);
  modport sink (input valid, input byte_in, input message_start, output ready);
endinterface

// ----- sv/vbc_out_if.sv -----
// Output channel of the Vigenere byte cipher: valid/ready plus one result byte.
// Depends on vbc_pkg.
interface vbc_out_if;
  import vbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;

  modport source (output valid, output byte_out, input ready);
  modport sink (input valid, input byte_out, output ready);
endinterface

// ----- sv/vbc_front.sv -----
// Front end: accepts items, classifies letters, tracks the key position and
// picks the effective shift. Depends on vbc_pkg and vbc_in_if.
module vbc_front #(
  parameter int MAX_KEY_LETTERS = vbc_pkg::MAX_KEY_LETTERS
) (
  input  logic                                clk,
  input  logic                                rst,
  vbc_in_if.sink                              in_port,
  input  logic [vbc_pkg::KEY_SHIFTS_W-1:0]    key_shifts,
  input  logic [vbc_pkg::KEY_LENGTH_W-1:0]    key_length,
  input  logic                                decrypt_mode,
  input  logic                                queue_full,
  output logic                                push,
  output vbc_pkg::queue_entry_t               push_entry
);
  import vbc_pkg::*;

  localparam logic [POS_W-1:0] MaxLen = POS_W'(MAX_KEY_LETTERS);

  logic [POS_W-1:0]   key_position;
  logic [POS_W-1:0]   key_position_next;
  logic [POS_W-1:0]   len;
  logic [POS_W-1:0]   pos_start;
  logic [POS_W-1:0]   pos_use;
  logic [POS_W-1:0]   pos_inc;
  logic [5:0]         shift_lsb;
  logic [SHIFT_W-1:0] raw_shift;
  logic [SHIFT_W-1:0] red_shift;
  logic [SHIFT_W-1:0] eff_shift;
  logic               letter;
  logic               active;

  assign in_port.ready = !queue_full;
  assign push          = in_port.valid && !queue_full;

  always_comb begin
    len       = (key_length > MaxLen) ? MaxLen : key_length;
    pos_start = in_port.message_start ? '0 : key_position;
    pos_use   = (pos_start >= len) ? '0 : pos_start;
    pos_inc   = pos_use + 1'b1;
    letter    = (in_port.byte_in >= CHAR_LOWER_A && in_port.byte_in <= CHAR_LOWER_Z) ||
                (in_port.byte_in >= CHAR_UPPER_A && in_port.byte_in <= CHAR_UPPER_Z);
    active    = letter && (len != '0);
    shift_lsb = 6'(pos_use) * 6'd5;
    raw_shift = key_shifts[shift_lsb +: SHIFT_W];
    red_shift = (raw_shift >= ALPHABET_LEN) ? raw_shift - ALPHABET_LEN : raw_shift;
    if (decrypt_mode && red_shift != '0) begin
      eff_shift = ALPHABET_LEN - red_shift;
    end else begin
      eff_shift = red_shift;
    end
    if (active) begin
      key_position_next = (pos_inc == len) ? '0 : pos_inc;
    end else begin
      key_position_next = pos_start;
    end
    push_entry.data   = in_port.byte_in;
    push_entry.letter = active;
    push_entry.shift  = eff_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
    end else if (push) begin
      key_position <= key_position_next;
    end
  end

endmodule

// ----- sv/vbc_queue.sv -----
// Short item queue between the front end and the back end.
// Depends on vbc_pkg.
module vbc_queue #(
  parameter int DEPTH = vbc_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  vbc_pkg::queue_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output vbc_pkg::queue_entry_t pop_entry,
  output logic                  not_empty
);
  import vbc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  queue_entry_t    mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/vbc_back.sv -----
// Back end: applies the shift modulo 26 within the letter's case and holds
// the result in the output register. Depends on vbc_pkg and vbc_out_if.
module vbc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  not_empty,
  input  vbc_pkg::queue_entry_t entry,
  output logic                  pop,
  vbc_out_if.source             out_port
);
  import vbc_pkg::*;

  logic [SHIFT_W-1:0] letter_idx;
  logic [SHIFT_W:0]   sum;
  logic [SHIFT_W:0]   wrapped;
  logic [BYTE_W-1:0]  result;

  assign pop = not_empty && (!out_port.valid || out_port.ready);

  // Letters carry 1..26 in their low five bits; the case sits in bit 5.
  always_comb begin
    letter_idx = entry.data[SHIFT_W-1:0] - 1'b1;
    sum        = {1'b0, letter_idx} + {1'b0, entry.shift};
    wrapped    = (sum >= {1'b0, ALPHABET_LEN}) ? sum - {1'b0, ALPHABET_LEN} : sum;
    if (entry.letter) begin
      result = {entry.data[BYTE_W-1:SHIFT_W], wrapped[SHIFT_W-1:0] + 1'b1};
    end else begin
      result = entry.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_port.valid <= 1'b0;
    end else if (pop) begin
      out_port.valid <= 1'b1;
    end else if (out_port.ready) begin
      out_port.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_port.byte_out <= result;
    end
  end

endmodule

// ----- sv/vigenere_byte_cipher.sv -----
// Vigenere byte cipher, top level: configuration registers, front end,
// item queue and back end. Depends on vbc_pkg, vbc_in_if, vbc_out_if,
// vbc_front, vbc_queue and vbc_back.
//
// One byte in, one byte out. ASCII letters are shifted modulo 26 within
// their case by the current key letter (added in encrypt mode, subtracted
// in decrypt mode); other bytes pass unchanged and do not advance the key.
// message_start restarts the key at letter zero; a key length of zero
// passes every byte through. The block takes one item per cycle while the
// queue is not full. The combinational front end writes each accepted item
// into the queue at the accepting edge, and the back end moves it into its
// output register once that register is free. The queue absorbs output
// stalls, so input ready drops only once the queue is full. Write the
// configuration registers only while no items are in flight.
module vigenere_byte_cipher #(
  parameter int MAX_KEY_LETTERS = vbc_pkg::MAX_KEY_LETTERS,
  parameter int QUEUE_DEPTH     = vbc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  vbc_in_if.sink                          stream_in,
  vbc_out_if.source                       stream_out,
  input  logic                            write_enable,
  input  logic [vbc_pkg::CFG_INDEX_W-1:0] write_index,
  input  logic [vbc_pkg::CFG_DATA_W-1:0]  write_data
);
  import vbc_pkg::*;

  logic [KEY_SHIFTS_W-1:0] key_shifts;
  logic [KEY_LENGTH_W-1:0] key_length;
  logic                    decrypt_mode;
  logic                    push;
  logic                    pop;
  logic                    queue_full;
  logic                    queue_not_empty;
  queue_entry_t            push_entry;
  queue_entry_t            pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_shifts   <= '0;
      key_length   <= '0;
      decrypt_mode <= 1'b0;
    end else if (write_enable) begin
      unique case (write_index)
        REG_KEY_SHIFTS:   key_shifts   <= write_data[KEY_SHIFTS_W-1:0];
        REG_KEY_LENGTH:   key_length   <= write_data[KEY_LENGTH_W-1:0];
        REG_DECRYPT_MODE: decrypt_mode <= write_data[0];
        default: ;
      endcase
    end
  end

  vbc_front #(
    .MAX_KEY_LETTERS(MAX_KEY_LETTERS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_port      (stream_in),
    .key_shifts   (key_shifts),
    .key_length   (key_length),
    .decrypt_mode (decrypt_mode),
    .queue_full   (queue_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  vbc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (queue_not_empty)
  );

  vbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (queue_not_empty),
    .entry     (pop_entry),
    .pop       (pop),
    .out_port  (stream_out)
  );

endmodule
